### rtl/core/weighted_histogram_argmax_macros.svh
// ---------------------------------------------------------------------------
// Weighted histogram argmax: assertion macros
// Shared concurrent assertion forms used by the core modules.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_HISTOGRAM_ARGMAX_MACROS_SVH
`define WEIGHTED_HISTOGRAM_ARGMAX_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WHA_ASSERT_NOW(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define WHA_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/core/wha_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wha_pkg
// Widths, constants and inter-module structs for the weighted histogram.
// ---------------------------------------------------------------------------
package wha_pkg;

    localparam int IDX_W     = 10;
    localparam int WT_W      = 16;
    localparam int TOT_W     = 32;
    localparam int IDX_SPAN  = 1 << IDX_W;   // bins reachable by the index field
    localparam int S_TDATA_W = 32;           // 26 payload bits padded to bytes
    localparam int M_TDATA_W = 48;           // 42 payload bits padded to bytes

    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    // Write request into the bin store.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [TOT_W-1:0] total;
    } t_bin_wr;

    // Leader as reported on the result word.
    typedef struct packed {
        logic [IDX_W-1:0] bin;
        logic [TOT_W-1:0] total;
    } t_leader;

endpackage

### rtl/core/wha_bin_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wha_bin_ram
// Bin total store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module wha_bin_ram #(
    parameter int DEPTH = 1024
) (
    input  logic                          i_clk,
    input  wha_pkg::t_bin_wr              i_wr,
    input  logic                          i_rd_en,
    input  logic [wha_pkg::IDX_W-1:0]     i_rd_idx,
    output logic [wha_pkg::TOT_W-1:0]     o_rd_total
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [wha_pkg::TOT_W-1:0] r_mem [0:DEPTH-1];
    logic [wha_pkg::TOT_W-1:0] r_rd_total;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx[AW-1:0]] <= i_wr.total;
        end
        if (i_rd_en) begin
            r_rd_total <= r_mem[i_rd_idx[AW-1:0]];
        end
    end

    assign o_rd_total = r_rd_total;

endmodule

### rtl/core/wha_update.sv
`timescale 1ns / 1ps
`include "weighted_histogram_argmax_macros.svh"
// ---------------------------------------------------------------------------
// wha_update
// Saturating accumulate of one bin and running leader tracking.
// ---------------------------------------------------------------------------
module wha_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,      // item leaves the update stage
    input  logic                          i_in_range,
    input  logic [wha_pkg::IDX_W-1:0]     i_idx,
    input  logic [wha_pkg::WT_W-1:0]      i_wt,
    input  logic [wha_pkg::TOT_W-1:0]     i_rd_total,
    input  logic                          i_fwd,       // store read was stale
    input  logic [wha_pkg::TOT_W-1:0]     i_fwd_total,
    output wha_pkg::t_bin_wr              o_wr,
    output wha_pkg::t_leader              o_leader
);

    logic                       r_best_valid;
    logic [wha_pkg::IDX_W-1:0]  r_best_bin;
    logic [wha_pkg::TOT_W-1:0]  r_best_total;
    logic                       n_best_valid;
    logic [wha_pkg::IDX_W-1:0]  n_best_bin;
    logic [wha_pkg::TOT_W-1:0]  n_best_total;

    logic [wha_pkg::TOT_W-1:0]  old_total;
    logic [wha_pkg::TOT_W:0]    raw_sum;
    logic [wha_pkg::TOT_W-1:0]  sum;
    logic                       take_lead;

    always_comb begin
        old_total = i_fwd ? i_fwd_total : i_rd_total;
        raw_sum   = {1'b0, old_total} + {{(wha_pkg::TOT_W + 1 - wha_pkg::WT_W){1'b0}}, i_wt};
        sum       = raw_sum[wha_pkg::TOT_W] ? wha_pkg::TOT_MAX : raw_sum[wha_pkg::TOT_W-1:0];
        // strict compare: an equal total never steals the lead
        take_lead = i_in_range && (!r_best_valid || (sum > r_best_total));

        n_best_valid = r_best_valid | take_lead;
        n_best_bin   = take_lead ? i_idx : r_best_bin;
        n_best_total = take_lead ? sum   : r_best_total;
    end

    always_comb begin
        o_wr.en       = i_fire && i_in_range;
        o_wr.idx      = i_idx;
        o_wr.total    = sum;
        o_leader.bin   = n_best_valid ? n_best_bin   : '0;
        o_leader.total = n_best_valid ? n_best_total : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid <= 1'b0;
            r_best_bin   <= '0;
            r_best_total <= '0;
        end else if (i_fire) begin
            r_best_valid <= n_best_valid;
            r_best_bin   <= n_best_bin;
            r_best_total <= n_best_total;
        end
    end

    `WHA_ASSERT_NOW(a_lead_monotone, i_clk, i_rst_n, $past(i_rst_n), r_best_total >= $past(r_best_total), "leader total decreased")
    `WHA_ASSERT_NOW(a_no_lead_zero, i_clk, i_rst_n, !r_best_valid, (r_best_total == '0) && (r_best_bin == '0), "leader set without valid")

endmodule

### rtl/core/weighted_histogram_argmax.sv
`timescale 1ns / 1ps
`include "weighted_histogram_argmax_macros.svh"
// ---------------------------------------------------------------------------
// weighted_histogram_argmax
// Weighted histogram over up to 1024 bins with running argmax output.
// ---------------------------------------------------------------------------
//
//  port group  dir  fields (low bit up)                     handshake
//  ----------  ---  --------------------------------------  ------------------
//  s_*         in   bin_index[9:0], weight[25:10], pad      s_tvalid/s_tready
//  m_*         out  leader_bin[9:0], leader_total[41:10],   m_tvalid/m_tready
//                   pad
//
//  Throughput: one word per cycle sustained while m_tready stays high and
//  no clearing pass runs. The bin store is read when a word is accepted
//  and written back when that word leaves the update stage; a read that
//  collides with that write-back takes the written total from a forwarding
//  register. The result word is registered in the update stage, then in the
//  output register. Reset: synchronous; then a clearing pass writes zero
//  to all min(NUM_BINS,1024) bins, one per cycle, with s_tready held low.
//  Stalls: the output register frees the update stage whenever m_tready is
//  high or no result is pending; s_tready follows combinationally.
// ---------------------------------------------------------------------------
module weighted_histogram_argmax #(
    parameter int NUM_BINS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [wha_pkg::S_TDATA_W-1:0]    s_tdata,   // bin_index, weight
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wha_pkg::M_TDATA_W-1:0]    m_tdata    // leader_bin, leader_total
);

    // only the first 1024 bins are reachable by the index field
    localparam int MEM_DEPTH = (NUM_BINS > wha_pkg::IDX_SPAN) ? wha_pkg::IDX_SPAN : NUM_BINS;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_DEPTH - 1);

    // input unpack
    logic [wha_pkg::IDX_W-1:0] s_idx;
    logic [wha_pkg::WT_W-1:0]  s_wt;
    logic                      s_in_range;
    logic                      s_accept;

    assign s_idx      = s_tdata[wha_pkg::IDX_W-1:0];
    assign s_wt       = s_tdata[wha_pkg::IDX_W +: wha_pkg::WT_W];
    assign s_in_range = (32'(s_idx) < 32'(NUM_BINS));

    // clearing pass
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    // update stage registers
    logic                       r_s1_valid;
    logic                       r_s1_in_range;
    logic [wha_pkg::IDX_W-1:0]  r_s1_idx;
    logic [wha_pkg::WT_W-1:0]   r_s1_wt;
    logic                       r_s1_fwd;
    logic [wha_pkg::TOT_W-1:0]  r_s1_fwd_total;
    logic                       s1_fire;

    // output register
    logic                       r_m_valid;
    wha_pkg::t_leader           r_m_leader;

    // store interface
    wha_pkg::t_bin_wr           upd_wr;
    wha_pkg::t_bin_wr           ram_wr;
    logic [wha_pkg::TOT_W-1:0]  rd_total;
    wha_pkg::t_leader           upd_leader;

    assign s1_fire  = r_s1_valid && (!r_m_valid || m_tready);
    assign s_tready = !r_clearing && (!r_s1_valid || s1_fire);
    assign s_accept = s_tvalid && s_tready;

    // clearing pass owns the write port until it is done
    always_comb begin
        if (r_clearing) begin
            ram_wr.en    = 1'b1;
            ram_wr.idx   = wha_pkg::IDX_W'(r_clr_addr);
            ram_wr.total = '0;
        end else begin
            ram_wr = upd_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CLR_LAST) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // stage 1 load; the store read issued here returns pre-write data when
    // the item ahead writes the same bin at this edge, so capture that write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_in_range  <= s_in_range;
            r_s1_idx       <= s_idx;
            r_s1_wt        <= s_wt;
            r_s1_fwd       <= upd_wr.en && (upd_wr.idx == s_idx);
            r_s1_fwd_total <= upd_wr.total;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s1_fire) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_m_leader <= upd_leader;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {{(wha_pkg::M_TDATA_W - wha_pkg::IDX_W - wha_pkg::TOT_W){1'b0}},
                       r_m_leader.total, r_m_leader.bin};

    wha_bin_ram #(
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk      (i_clk),
        .i_wr       (ram_wr),
        .i_rd_en    (s_accept && s_in_range),
        .i_rd_idx   (s_idx),
        .o_rd_total (rd_total)
    );

    wha_update u_upd (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (s1_fire),
        .i_in_range  (r_s1_in_range),
        .i_idx       (r_s1_idx),
        .i_wt        (r_s1_wt),
        .i_rd_total  (rd_total),
        .i_fwd       (r_s1_fwd),
        .i_fwd_total (r_s1_fwd_total),
        .o_wr        (upd_wr),
        .o_leader    (upd_leader)
    );

    `WHA_ASSERT_NOW(a_clear_idle, i_clk, i_rst_n, r_clearing,
                    !r_s1_valid && !r_m_valid, "item in flight during clearing pass")
    `WHA_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s1_fire,
                     r_s1_valid && $stable(r_s1_idx), "stalled update stage lost its item")

endmodule
